/* rtl/core/tpks_pkg.sv */
// ----------------------------------------------------------------------------
// tpks_pkg
// Shared types and constants for the timed pose keyframe sequencer.
// ----------------------------------------------------------------------------
package tpks_pkg;

  localparam int unsigned DEF_MAX_KEYFRAMES = 8;
  localparam int unsigned DEF_JOINT_COUNT   = 7;
  localparam int unsigned DEF_ANGLE_BITS    = 16;
  localparam int unsigned DEF_TIME_BITS     = 24;

  localparam int unsigned IDX_BITS  = 3;   // keyframe/joint index fields
  localparam int unsigned STEP_BITS = 16;
  localparam int unsigned CFG_BITS  = 4;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_TARGET = 2'd2,
    OP_TIMING = 2'd3
  } op_e;

  // controller -> datapath
  typedef struct packed {
    logic load_in;
    logic do_write;
    logic do_time;
    logic do_adv;
    logic cap_rd;
    logic cap_wr;
    logic j_clr;
    logic j_inc;
    logic emit_rd;
    logic calc;
    logic div_step;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_e  op;
    logic advance;
    logic j_last;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

/* rtl/core/tpks_ram.sv */
// ----------------------------------------------------------------------------
// tpks_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tpks_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/tpks_ctrl.sv */
// ----------------------------------------------------------------------------
// tpks_ctrl
// Sequencer: decodes each transaction and steps the datapath through the
// capture and per-joint interpolation passes.
// ----------------------------------------------------------------------------
module tpks_ctrl
  import tpks_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_valid_i,
  output logic s_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_CHECK,
    ST_CAP_RD,
    ST_CAP_WR,
    ST_EM_RD,
    ST_CALC,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e state_q, state_d;
  cmd_t   cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          cmd.load_in = 1'b1;
          state_d     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.op == OP_TICK) begin
          cmd.do_time = 1'b1;
          state_d     = ST_CHECK;
        end else begin
          cmd.do_write = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      ST_CHECK: begin
        cmd.j_clr = 1'b1;
        state_d   = sts_i.advance ? ST_CAP_RD : ST_EM_RD;
      end
      ST_CAP_RD: begin
        cmd.cap_rd = 1'b1;
        state_d    = ST_CAP_WR;
      end
      ST_CAP_WR: begin
        cmd.cap_wr = 1'b1;
        if (sts_i.j_last) begin
          cmd.do_adv = 1'b1;
          cmd.j_clr  = 1'b1;
          state_d    = ST_EM_RD;
        end else begin
          cmd.j_inc = 1'b1;
          state_d   = ST_CAP_RD;
        end
      end
      ST_EM_RD: begin
        cmd.emit_rd = 1'b1;
        state_d     = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc = 1'b1;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_OUT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_OUT: begin
        if (!sts_i.out_busy) begin
          cmd.out_load = 1'b1;
          if (sts_i.j_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd.j_inc = 1'b1;
            state_d   = ST_EM_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_ready_o = (state_q == ST_IDLE);
  assign cmd_o     = cmd;

  a_load_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_in |=> state_q == ST_DECODE)
    else $error("accepted transaction not decoded");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> !sts_i.out_busy)
    else $error("output register overwritten while stalled");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step |-> !sts_i.div_done)
    else $error("divider stepped past completion");

  a_adv_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.do_adv |-> sts_i.j_last && state_q == ST_CAP_WR)
    else $error("keyframe advanced before capture finished");

endmodule

/* rtl/core/tpks_dp.sv */
// ----------------------------------------------------------------------------
// tpks_dp
// Datapath: keyframe tables, sample buffer, elapsed time, interpolation
// multiplier and a bit-serial restoring divider, plus the output register.
// ----------------------------------------------------------------------------
module tpks_dp
  import tpks_pkg::*;
#(
  parameter int unsigned MAX_KEYFRAMES = DEF_MAX_KEYFRAMES,
  parameter int unsigned JOINT_COUNT   = DEF_JOINT_COUNT,
  parameter int unsigned ANGLE_BITS    = DEF_ANGLE_BITS,
  parameter int unsigned TIME_BITS     = DEF_TIME_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_BITS-1:0]   cfg_wdata_i,
  input  logic [1:0]            in_op_i,
  input  logic [IDX_BITS-1:0]   in_kf_i,
  input  logic [IDX_BITS-1:0]   in_jt_i,
  input  logic [ANGLE_BITS-1:0] in_target_i,
  input  logic                  in_local_i,
  input  logic [TIME_BITS-1:0]  in_hold_i,
  input  logic [IDX_BITS-1:0]   in_next_i,
  input  logic [STEP_BITS-1:0]  in_step_i,
  input  logic [ANGLE_BITS-1:0] in_lang_i,
  input  logic [ANGLE_BITS-1:0] in_gang_i,
  input  logic                  m_ready_i,
  output logic                  m_valid_o,
  output logic [IDX_BITS-1:0]   m_joint_o,
  output logic [ANGLE_BITS-1:0] m_angle_o,
  output logic [IDX_BITS-1:0]   m_kf_o,
  output logic                  m_last_o
);

  localparam int unsigned KW    = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1;
  localparam int unsigned JW    = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
  localparam int unsigned DEPTH = MAX_KEYFRAMES * JOINT_COUNT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned EW    = ANGLE_BITS + 1;           // angle + local flag
  localparam int unsigned PW    = ANGLE_BITS + 1 + TIME_BITS;
  localparam int unsigned CW    = $clog2(PW + 1);

  // input transaction
  op_e                   op_q;
  logic [IDX_BITS-1:0]   kf_q, jt_q, nx_q;
  logic [ANGLE_BITS-1:0] tgt_q, lang_q, gang_q;
  logic                  loc_q;
  logic [TIME_BITS-1:0]  hold_in_q;
  logic [STEP_BITS-1:0]  step_q;

  logic [CFG_BITS-1:0]   kiu_q;
  logic [KW-1:0]         cur_q;
  logic [TIME_BITS-1:0]  el_q;
  logic [TIME_BITS-1:0]  hold_q [MAX_KEYFRAMES];
  logic [KW-1:0]         succ_q [MAX_KEYFRAMES];
  logic [ANGLE_BITS-1:0] start_q [JOINT_COUNT];
  logic [ANGLE_BITS-1:0] sl_q [JOINT_COUNT];
  logic [ANGLE_BITS-1:0] sg_q [JOINT_COUNT];
  logic [DEPTH-1:0]      vld_q;
  logic                  rd_vld_q;
  logic [JW-1:0]         j_q;

  // interpolation
  logic                  neg_q, use_div_q;
  logic [ANGLE_BITS-1:0] x1_q, res_q;
  logic [TIME_BITS-1:0]  h_q;
  logic [PW-1:0]         dvd_q;
  logic [TIME_BITS:0]    rem_q;
  logic [CW-1:0]         cnt_q;

  logic                  m_valid_q, m_last_q;
  logic [IDX_BITS-1:0]   m_joint_q, m_kf_q;
  logic [ANGLE_BITS-1:0] m_angle_q;

  logic                  multi, kf_ok, jt_ok, ram_we, ram_re;
  logic [KW-1:0]         kf_i, nx_kf;
  logic [JW-1:0]         jt_i;
  logic [AW-1:0]         waddr, raddr;
  logic [EW-1:0]         rdata, entry;
  logic [TIME_BITS:0]    el_sum;
  logic [TIME_BITS-1:0]  cur_hold;

  assign multi    = kiu_q > CFG_BITS'(1);
  assign kf_ok    = 32'(kf_q) < MAX_KEYFRAMES;
  assign jt_ok    = 32'(jt_q) < JOINT_COUNT;
  assign kf_i     = KW'(kf_q);
  assign jt_i     = JW'(jt_q);
  assign nx_kf    = succ_q[cur_q];
  assign cur_hold = hold_q[cur_q];
  assign el_sum   = {1'b0, el_q} + (TIME_BITS+1)'(step_q);

  assign ram_we = cmd_i.do_write && op_q == OP_TARGET && kf_ok && jt_ok;
  assign ram_re = cmd_i.cap_rd || cmd_i.emit_rd;
  assign waddr  = AW'(32'(kf_i) * JOINT_COUNT + 32'(jt_i));
  assign raddr  = AW'(32'(cmd_i.cap_rd ? nx_kf : cur_q) * JOINT_COUNT + 32'(j_q));
  assign entry  = rd_vld_q ? rdata : '0;

  tpks_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_tbl (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i ({loc_q, tgt_q}),
    .re_i    (ram_re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // interpolation set-up
  logic signed [ANGLE_BITS-1:0] x1s, x2s;
  logic signed [ANGLE_BITS:0]   diff;
  logic        [ANGLE_BITS:0]   mag;
  logic        [PW-1:0]         prod;
  logic                         raw, need_div;
  logic        [ANGLE_BITS-1:0] quick;

  always_comb begin
    x1s  = $signed(start_q[j_q]);
    x2s  = $signed(entry[ANGLE_BITS-1:0]);
    diff = {x2s[ANGLE_BITS-1], x2s} - {x1s[ANGLE_BITS-1], x1s};
    mag  = diff[ANGLE_BITS] ? (~diff + 1'b1) : diff;
    prod = {{TIME_BITS{1'b0}}, mag} * {{(ANGLE_BITS+1){1'b0}}, el_q};
    raw  = !multi || cur_hold == '0;
    need_div = 1'b0;
    if (raw) begin
      quick = entry[ANGLE_BITS-1:0];
    end else if (x1s == x2s || el_q == '0) begin
      quick = start_q[j_q];
    end else if (el_q >= cur_hold) begin
      quick = entry[ANGLE_BITS-1:0];
    end else begin
      quick    = start_q[j_q];
      need_div = 1'b1;
    end
  end

  // one restoring division step per cycle
  logic [TIME_BITS:0] rem_sh;
  logic               ge;
  assign rem_sh = {rem_q[TIME_BITS-1:0], dvd_q[PW-1]};
  assign ge     = rem_sh >= {1'b0, h_q};

  logic [ANGLE_BITS:0] x1e, qe, fin;
  always_comb begin
    x1e = {x1_q[ANGLE_BITS-1], x1_q};
    qe  = dvd_q[ANGLE_BITS:0];
    fin = neg_q ? (x1e - qe) : (x1e + qe);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q      <= op_e'(in_op_i);
      kf_q      <= in_kf_i;
      jt_q      <= in_jt_i;
      tgt_q     <= in_target_i;
      loc_q     <= in_local_i;
      hold_in_q <= in_hold_i;
      nx_q      <= in_next_i;
      step_q    <= in_step_i;
      lang_q    <= in_lang_i;
      gang_q    <= in_gang_i;
    end
    if (cmd_i.calc) begin
      neg_q     <= diff[ANGLE_BITS];
      use_div_q <= need_div;
      x1_q      <= start_q[j_q];
      res_q     <= quick;
      h_q       <= cur_hold;
      dvd_q     <= prod;
      rem_q     <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[PW-2:0], ge};
      rem_q <= ge ? (rem_sh - {1'b0, h_q}) : rem_sh;
    end
    if (cmd_i.out_load) begin
      m_joint_q <= IDX_BITS'(j_q);
      m_angle_q <= use_div_q ? fin[ANGLE_BITS-1:0] : res_q;
      m_kf_q    <= IDX_BITS'(cur_q);
      m_last_q  <= 32'(j_q) == JOINT_COUNT - 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kiu_q     <= CFG_BITS'(1);
      cur_q     <= '0;
      el_q      <= '0;
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      j_q       <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
      for (int k = 0; k < MAX_KEYFRAMES; k++) begin
        hold_q[k] <= '0;
        succ_q[k] <= '0;
      end
      for (int k = 0; k < JOINT_COUNT; k++) begin
        start_q[k] <= '0;
        sl_q[k]    <= '0;
        sg_q[k]    <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        kiu_q <= cfg_wdata_i;
      end
      if (cmd_i.do_write) begin
        case (op_q)
          OP_SAMPLE: begin
            if (jt_ok) begin
              sl_q[jt_i] <= lang_q;
              sg_q[jt_i] <= gang_q;
            end
          end
          OP_TARGET: begin
            if (kf_ok && jt_ok) begin
              vld_q[waddr] <= 1'b1;
              if (kf_q == '0) begin
                start_q[jt_i] <= tgt_q;
              end
            end
          end
          OP_TIMING: begin
            if (kf_ok) begin
              hold_q[kf_i] <= hold_in_q;
              succ_q[kf_i] <= (32'(nx_q) < MAX_KEYFRAMES) ? KW'(nx_q) : '0;
            end
          end
          default: ;
        endcase
      end
      if (cmd_i.do_time) begin
        el_q <= el_sum[TIME_BITS] ? '1 : el_sum[TIME_BITS-1:0];
      end
      if (ram_re) begin
        rd_vld_q <= vld_q[raddr];
      end
      if (cmd_i.cap_wr) begin
        start_q[j_q] <= entry[ANGLE_BITS] ? sl_q[j_q] : sg_q[j_q];
      end
      if (cmd_i.do_adv) begin
        el_q  <= '0;
        cur_q <= nx_kf;
      end
      if (cmd_i.j_clr) begin
        j_q <= '0;
      end else if (cmd_i.j_inc) begin
        j_q <= j_q + 1'b1;
      end
      if (cmd_i.calc) begin
        cnt_q <= need_div ? '0 : CW'(PW);
      end else if (cmd_i.div_step) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.op       = op_q;
  assign sts_o.advance  = multi && (el_q > cur_hold);
  assign sts_o.j_last   = 32'(j_q) == JOINT_COUNT - 1;
  assign sts_o.div_done = cnt_q == CW'(PW);
  assign sts_o.out_busy = m_valid_q && !m_ready_i;

  assign m_valid_o = m_valid_q;
  assign m_joint_o = m_joint_q;
  assign m_angle_o = m_angle_q;
  assign m_kf_o    = m_kf_q;
  assign m_last_o  = m_last_q;

endmodule

/* rtl/core/timed_pose_keyframe_sequencer_top.sv */
// ----------------------------------------------------------------------------
// timed_pose_keyframe_sequencer_top
// Keyframe pose sequencer with linear interpolation between poses.
// ----------------------------------------------------------------------------
// Input stream: tuser carries the op (tick, sample, target write, timing
// write); tdata carries the payload. One transaction is taken at a time.
// Table writes and samples produce no output. A tick produces JOINT_COUNT
// output transactions, one per joint, tlast on the final one. A joint that
// needs a division runs the bit-serial divider; any other joint skips the
// division steps. A tick that advances to the next keyframe first runs a
// start-angle capture pass over every joint. The output register holds a
// result until tready; while stalled the sequencer waits, and tready on the
// input side stays low until the last result of the tick is in the output
// register. keyframes_in_use is written through cfg_we_i; the user must
// write it only while idle, as the block itself does not enforce this.
// Reset invalidates the target table and clears the timing tables, samples,
// time, start angles and the keyframe pointer; keyframes_in_use resets to
// one.
// ----------------------------------------------------------------------------
module timed_pose_keyframe_sequencer_top
  import tpks_pkg::*;
#(
  parameter int unsigned MAX_KEYFRAMES = DEF_MAX_KEYFRAMES,
  parameter int unsigned JOINT_COUNT   = DEF_JOINT_COUNT,
  parameter int unsigned ANGLE_BITS    = DEF_ANGLE_BITS,
  parameter int unsigned TIME_BITS     = DEF_TIME_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_BITS-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // keyframe_index, joint_index, target_angle, target_is_local, hold_time,
  // next_keyframe, step_time, local_angle, global_angle
  input  logic [((3*IDX_BITS + 1 + STEP_BITS + 3*ANGLE_BITS + TIME_BITS) + 7)
                / 8 * 8 - 1:0] s_axis_tdata_i,
  // op
  input  logic [1:0]          s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // joint_number, commanded_angle, active_keyframe
  output logic [((2*IDX_BITS + ANGLE_BITS) + 7) / 8 * 8 - 1:0] m_axis_tdata_o,
  output logic                m_axis_tlast_o
);

  localparam int unsigned O_KF = 0;
  localparam int unsigned O_JT = O_KF + IDX_BITS;
  localparam int unsigned O_TG = O_JT + IDX_BITS;
  localparam int unsigned O_LC = O_TG + ANGLE_BITS;
  localparam int unsigned O_HD = O_LC + 1;
  localparam int unsigned O_NX = O_HD + TIME_BITS;
  localparam int unsigned O_ST = O_NX + IDX_BITS;
  localparam int unsigned O_LA = O_ST + STEP_BITS;
  localparam int unsigned O_GA = O_LA + ANGLE_BITS;
  localparam int unsigned M_W  = 2*IDX_BITS + ANGLE_BITS;
  localparam int unsigned M_DW = (M_W + 7) / 8 * 8;

  cmd_t                  cmd;
  sts_t                  sts;
  logic [IDX_BITS-1:0]   m_joint, m_kf;
  logic [ANGLE_BITS-1:0] m_angle;

  tpks_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  tpks_dp #(
    .MAX_KEYFRAMES (MAX_KEYFRAMES),
    .JOINT_COUNT   (JOINT_COUNT),
    .ANGLE_BITS    (ANGLE_BITS),
    .TIME_BITS     (TIME_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_op_i     (s_axis_tuser_i),
    .in_kf_i     (s_axis_tdata_i[O_KF +: IDX_BITS]),
    .in_jt_i     (s_axis_tdata_i[O_JT +: IDX_BITS]),
    .in_target_i (s_axis_tdata_i[O_TG +: ANGLE_BITS]),
    .in_local_i  (s_axis_tdata_i[O_LC]),
    .in_hold_i   (s_axis_tdata_i[O_HD +: TIME_BITS]),
    .in_next_i   (s_axis_tdata_i[O_NX +: IDX_BITS]),
    .in_step_i   (s_axis_tdata_i[O_ST +: STEP_BITS]),
    .in_lang_i   (s_axis_tdata_i[O_LA +: ANGLE_BITS]),
    .in_gang_i   (s_axis_tdata_i[O_GA +: ANGLE_BITS]),
    .m_ready_i   (m_axis_tready_i),
    .m_valid_o   (m_axis_tvalid_o),
    .m_joint_o   (m_joint),
    .m_angle_o   (m_angle),
    .m_kf_o      (m_kf),
    .m_last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = M_DW'({m_kf, m_angle, m_joint});

endmodule

/* test/timed_pose_keyframe_sequencer_top_checker.sv */
// ----------------------------------------------------------------------------
// timed_pose_keyframe_sequencer_top_checker
// Watches both streams and the configuration port and keeps its own model
// of the keyframe sequencer. Every tick queues one commanded angle per joint,
// and each output transaction is checked field by field against that queue.
// ----------------------------------------------------------------------------
module timed_pose_keyframe_sequencer_top_checker
  import tpks_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CFG_BITS-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid_i,
  input  logic                s_axis_tready_i,
  input  logic [103:0]        s_axis_tdata_i,
  input  logic [1:0]          s_axis_tuser_i,
  input  logic                m_axis_tvalid_i,
  input  logic                m_axis_tready_i,
  input  logic [23:0]         m_axis_tdata_i,
  input  logic                m_axis_tlast_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  cmd_seen_o,
  output int                  advances_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NKF = DEF_MAX_KEYFRAMES;
  localparam int NJ  = DEF_JOINT_COUNT;
  localparam logic [23:0] TIME_ALL_ONES = 24'hFF_FFFF;

  typedef struct packed {
    logic [2:0]  joint;
    logic [15:0] angle;
    logic [2:0]  keyframe;
    logic        last;
  } command_t;

  command_t          cmd_q[$];
  logic [3:0]        kf_in_use;
  logic [2:0]        cur_kf;
  logic [23:0]       elapsed;
  logic signed [15:0] start_ang [NJ];
  logic signed [15:0] tgt_tab   [NKF*NJ];
  logic              loc_tab    [NKF*NJ];
  logic [23:0]       hold_tab   [NKF];
  logic [2:0]        succ_tab   [NKF];
  logic signed [15:0] samp_loc  [NJ];
  logic signed [15:0] samp_glb  [NJ];

  task automatic report(input string what, input command_t got, input command_t want);
    $display("MISMATCH %s: got j%0d a%0d k%0d l%0d, want j%0d a%0d k%0d l%0d", what,
             got.joint, $signed(got.angle), got.keyframe, got.last,
             want.joint, $signed(want.angle), want.keyframe, want.last);
    fail_count_o++;
  endtask

  // linear blend, truncating the step toward the start angle
  function automatic logic signed [15:0] blend(input logic signed [15:0] x1,
      input logic signed [15:0] x2, input logic [23:0] t, input logic [23:0] h);
    longint a, q;
    if (x1 == x2 || t == 0) return x1;
    if (t >= h) return x2;
    a = (x2 < x1) ? longint'(x1) - longint'(x2) : longint'(x2) - longint'(x1);
    q = (a * longint'(t)) / longint'(h);
    return (x2 < x1) ? 16'(longint'(x1) - q) : 16'(longint'(x1) + q);
  endfunction

  task automatic predict_tick(input logic [15:0] step);
    logic [24:0] sum;
    logic        multi;
    logic [2:0]  nx;
    command_t    c;
    multi = kf_in_use > 1;
    sum = elapsed + step;
    elapsed = sum[24] ? TIME_ALL_ONES : sum[23:0];
    if (multi && elapsed > hold_tab[cur_kf]) begin
      nx = succ_tab[cur_kf];
      elapsed = '0;
      for (int j = 0; j < NJ; j++)
        start_ang[j] = loc_tab[nx*NJ+j] ? samp_loc[j] : samp_glb[j];
      cur_kf = nx;
      advances_o++;
    end
    for (int j = 0; j < NJ; j++) begin
      c.joint    = 3'(j);
      c.angle    = (!multi || hold_tab[cur_kf] == 0) ? tgt_tab[cur_kf*NJ+j] :
                   blend(start_ang[j], tgt_tab[cur_kf*NJ+j], elapsed, hold_tab[cur_kf]);
      c.keyframe = cur_kf;
      c.last     = (j == NJ-1);
      cmd_q.insert(cmd_q.size(), c);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [2:0] kf, jt;
    command_t   got;
    if (!rst_ni) begin
      cmd_q.delete();
      kf_in_use = 4'd1;
      cur_kf = '0;
      elapsed = '0;
      for (int i = 0; i < NJ; i++) begin
        start_ang[i] = '0; samp_loc[i] = '0; samp_glb[i] = '0;
      end
      for (int i = 0; i < NKF*NJ; i++) begin
        tgt_tab[i] = '0; loc_tab[i] = 1'b0;
      end
      for (int i = 0; i < NKF; i++) begin
        hold_tab[i] = '0; succ_tab[i] = '0;
      end
    end else begin
      if (cfg_we_i) kf_in_use = cfg_wdata_i;
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = {m_axis_tdata_i[2:0], m_axis_tdata_i[18:3], m_axis_tdata_i[21:19],
               m_axis_tlast_i};
        cmd_seen_o++;
        if (cmd_q.size() == 0) begin
          report("unexpected transaction", got, got);
        end else begin
          if (got.joint != cmd_q[0].joint)       report("joint", got, cmd_q[0]);
          if (got.angle != cmd_q[0].angle)       report("angle", got, cmd_q[0]);
          if (got.keyframe != cmd_q[0].keyframe) report("keyframe", got, cmd_q[0]);
          if (got.last != cmd_q[0].last)         report("tlast", got, cmd_q[0]);
          void'(cmd_q.pop_front());
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        kf = s_axis_tdata_i[2:0];
        jt = s_axis_tdata_i[5:3];
        case (op_e'(s_axis_tuser_i))
          OP_TICK: predict_tick(s_axis_tdata_i[65:50]);
          OP_SAMPLE: begin
            if (jt < NJ) begin
              samp_loc[jt] = s_axis_tdata_i[81:66];
              samp_glb[jt] = s_axis_tdata_i[97:82];
            end
          end
          OP_TARGET: begin
            if (jt < NJ) begin
              tgt_tab[kf*NJ+jt] = s_axis_tdata_i[21:6];
              loc_tab[kf*NJ+jt] = s_axis_tdata_i[22];
              if (kf == 0) start_ang[jt] = s_axis_tdata_i[21:6];
            end
          end
          default: begin
            hold_tab[kf] = s_axis_tdata_i[46:23];
            succ_tab[kf] = s_axis_tdata_i[49:47];
          end
        endcase
      end
      pending_o = cmd_q.size();
    end
  end

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    cmd_seen_o = 0;
    advances_o = 0;
  end

endmodule

/* test/timed_pose_keyframe_sequencer_top_test.sv */
// ----------------------------------------------------------------------------
// timed_pose_keyframe_sequencer_top_test
// Loads keyframe tables, samples and ticks through the input stream under
// bursty input and a stalling output, over several keyframe counts, including
// elapsed-time saturation. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module timed_pose_keyframe_sequencer_top_test;
  import tpks_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CFG_BITS-1:0] cfg_wdata_i = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [103:0]        s_axis_tdata_i = '0;
  logic [1:0]          s_axis_tuser_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [23:0]         m_axis_tdata_o;
  logic                m_axis_tlast_o;
  int                  fail_count, pending, cmd_seen, advances;
  int                  burst_left = 0;
  int                  items_sent = 0;

  always #5 clk_i = ~clk_i;

  timed_pose_keyframe_sequencer_top DUT (.*);

  timed_pose_keyframe_sequencer_top_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid_i, .s_axis_tready_i(s_axis_tready_o), .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_i(m_axis_tvalid_o), .m_axis_tready_i, .m_axis_tdata_i(m_axis_tdata_o),
    .m_axis_tlast_i(m_axis_tlast_o),
    .fail_count_o(fail_count), .pending_o(pending), .cmd_seen_o(cmd_seen),
    .advances_o(advances)
  );

  // receiver: stall pattern is one of four modes, redrawn when its run ends
  always @(negedge clk_i) begin
    static int mode = 0, left = 0;
    if (left == 0) begin
      mode = $urandom_range(0, 3);
      left = $urandom_range(50, 400);
    end
    left--;
    case (mode)
      0:       m_axis_tready_i <= 1'b1;
      1:       m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      2:       m_axis_tready_i <= ($urandom_range(0, 1) != 0);
      default: m_axis_tready_i <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send(input op_e op, input logic [2:0] kf, input logic [2:0] jt,
      input logic [15:0] ang, input logic loc, input logic [23:0] hold,
      input logic [2:0] nx, input logic [15:0] step, input logic [15:0] la,
      input logic [15:0] ga);
    @(negedge clk_i);
    if (burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {6'b0, ga, la, step, nx, hold, loc, ang, jt, kf};
    do @(posedge clk_i); while (!s_axis_tready_o);
    burst_left--;
    items_sent++;
  endtask

  task automatic tick(input logic [15:0] step);
    send(OP_TICK, 3'($urandom), 3'($urandom), 16'($urandom), 1'($urandom), 24'($urandom),
         3'($urandom), step, 16'($urandom), 16'($urandom));
  endtask

  task automatic sample(input logic [2:0] jt, input logic [15:0] la, input logic [15:0] ga);
    send(OP_SAMPLE, 3'($urandom), jt, 16'($urandom), 1'($urandom), 24'($urandom),
         3'($urandom), 16'($urandom), la, ga);
  endtask

  task automatic set_target(input logic [2:0] kf, input logic [2:0] jt,
      input logic [15:0] ang, input logic loc);
    send(OP_TARGET, kf, jt, ang, loc, 24'($urandom), 3'($urandom), 16'($urandom),
         16'($urandom), 16'($urandom));
  endtask

  task automatic set_timing(input logic [2:0] kf, input logic [23:0] hold,
      input logic [2:0] nx);
    send(OP_TIMING, kf, 3'($urandom), 16'($urandom), 1'($urandom), hold, nx,
         16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // idle the input and wait for every queued command, then let the block settle
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [3:0] v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [23:0] rand_hold();
    case ($urandom_range(0, 7))
      0:       return 24'd0;
      1:       return 24'($urandom);
      2:       return 24'hFF_FFFF;
      default: return 24'($urandom_range(1, 3000));
    endcase
  endfunction

  function automatic logic [15:0] rand_step();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(1, 1500));
    endcase
  endfunction

  initial begin
    static logic [3:0] kf_counts [7] = '{4'd2, 4'd8, 4'd3, 4'd0, 4'd15, 4'd1, 4'd5};
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part
    tick(16'd0);
    set_target(3'd0, 3'd0, 16'h8000, 1'b1);
    set_target(3'd0, 3'd6, 16'h7FFF, 1'b0);
    set_target(3'd0, 3'd7, 16'h1234, 1'b1);        // joint out of range
    set_target(3'd1, 3'd0, 16'h7FFF, 1'b1);
    set_target(3'd1, 3'd6, 16'h8000, 1'b0);
    set_target(3'd7, 3'd3, 16'hFFFF, 1'b1);
    sample(3'd0, 16'h8000, 16'h7FFF);
    sample(3'd6, 16'h7FFF, 16'h8000);
    sample(3'd7, 16'h5555, 16'hAAAA);              // joint out of range
    set_timing(3'd0, 24'd0, 3'd1);
    set_timing(3'd1, 24'd100, 3'd7);               // successor past the cycle
    set_timing(3'd7, 24'hFF_FFFF, 3'd0);
    tick(16'hFFFF);                                // single keyframe, no advance
    write_cfg(4'd2);
    tick(16'd1);
    tick(16'd0);
    tick(16'd40);
    tick(16'd61);
    tick(16'd101);
    tick(16'hFFFF);

    // random part, one phase per keyframe count
    foreach (kf_counts[p]) begin
      write_cfg(kf_counts[p]);
      if (p == 2) drain();                         // sender pause with the output draining
      for (int n = 0; n < 11; n++) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7: tick(rand_step());
          8, 9, 10, 11: sample(3'($urandom_range(0, 7)), 16'($urandom), 16'($urandom));
          12, 13, 14, 15, 16:
            set_target(3'($urandom), 3'($urandom_range(0, 7)), 16'($urandom), 1'($urandom));
          default: set_timing(3'($urandom), rand_hold(), 3'($urandom));
        endcase
      end
    end

    // saturate elapsed time on a keyframe held for the full range
    write_cfg(4'd2);
    for (int k = 0; k < 8; k++) set_timing(3'(k), 24'hFF_FFFF, 3'($urandom));
    for (int n = 0; n < 258; n++) tick(16'hFFFF);
    for (int k = 0; k < 8; k++) set_timing(3'(k), 24'($urandom_range(1, 500)), 3'($urandom));
    tick(16'd1);
    tick(16'd300);

    drain();
    repeat (400) @(negedge clk_i);
    $display("Sent %0d input transactions; checked %0d commanded angles, %0d advances.",
             items_sent, cmd_seen, advances);
    $display("Covered keyframe counts 0 to 15, zero and saturated hold times, stalls.");
    if (fail_count == 0) begin
      $display("timed_pose_keyframe_sequencer_top_test: done, clean");
    end else begin
      $display("timed_pose_keyframe_sequencer_top_test: done, errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout with %0d commands outstanding", pending);
    $display("timed_pose_keyframe_sequencer_top_test: done, errors");
    $finish;
  end

endmodule
